### rtl/ruof_pkg.sv
package ruof_pkg;

    typedef logic signed [10:0] t_tone;

    typedef struct packed {
        t_tone lo0;
        t_tone hi0;
        t_tone lo1;
        t_tone hi1;
    } t_pair;

    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;

    localparam logic [1:0] W_160  = 2'd3;
    localparam logic [2:0] T_2X996 = 3'd6;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic       ref_bad;
        logic       direct;
        logic       last;
        logic       hit;
    } t_sts;

    function automatic logic [5:0] ru_count(input logic [1:0] pw, input logic [2:0] t);
        logic [5:0] n;
        n = 6'd0;
        case (pw)
            2'd0: begin
                case (t)
                    3'd0: n = 6'd9;
                    3'd1: n = 6'd4;
                    3'd2: n = 6'd2;
                    3'd3: n = 6'd1;
                    default: n = 6'd0;
                endcase
            end
            2'd1: begin
                case (t)
                    3'd0: n = 6'd18;
                    3'd1: n = 6'd8;
                    3'd2: n = 6'd4;
                    3'd3: n = 6'd2;
                    3'd4: n = 6'd1;
                    default: n = 6'd0;
                endcase
            end
            default: begin
                case (t)
                    3'd0: n = 6'd37;
                    3'd1: n = 6'd16;
                    3'd2: n = 6'd8;
                    3'd3: n = 6'd4;
                    3'd4: n = 6'd2;
                    3'd5: n = 6'd1;
                    default: n = 6'd0;
                endcase
            end
        endcase
        return n;
    endfunction

    function automatic logic [6:0] ru_base(input logic [1:0] pw, input logic [2:0] t);
        logic [6:0] b;
        b = 7'd0;
        case (pw)
            2'd0: begin
                case (t)
                    3'd1: b = 7'd9;
                    3'd2: b = 7'd13;
                    3'd3: b = 7'd15;
                    default: b = 7'd0;
                endcase
            end
            2'd1: begin
                case (t)
                    3'd0: b = 7'd16;
                    3'd1: b = 7'd34;
                    3'd2: b = 7'd42;
                    3'd3: b = 7'd46;
                    3'd4: b = 7'd48;
                    default: b = 7'd0;
                endcase
            end
            default: begin
                case (t)
                    3'd0: b = 7'd49;
                    3'd1: b = 7'd86;
                    3'd2: b = 7'd102;
                    3'd3: b = 7'd110;
                    3'd4: b = 7'd114;
                    3'd5: b = 7'd116;
                    default: b = 7'd0;
                endcase
            end
        endcase
        return b;
    endfunction

    function automatic t_pair sp(input int a, input int b);
        return '{t_tone'(a), t_tone'(b), t_tone'(a), t_tone'(b)};
    endfunction

    function automatic t_pair dp(input int a, input int b, input int c, input int d);
        return '{t_tone'(a), t_tone'(b), t_tone'(c), t_tone'(d)};
    endfunction

    function automatic t_pair plan(input logic [6:0] k);
        t_pair p;
        p = sp(0, 0);
        case (k)
            7'd0: p = sp(-121, -96);    7'd1: p = sp(-95, -70);
            7'd2: p = sp(-68, -43);     7'd3: p = sp(-42, -17);
            7'd4: p = dp(-16, -4, 4, 16);
            7'd5: p = sp(17, 42);       7'd6: p = sp(43, 68);
            7'd7: p = sp(70, 95);       7'd8: p = sp(96, 121);
            7'd9: p = sp(-121, -70);    7'd10: p = sp(-68, -17);
            7'd11: p = sp(17, 68);      7'd12: p = sp(70, 121);
            7'd13: p = sp(-122, -17);   7'd14: p = sp(17, 122);
            7'd15: p = dp(-122, -2, 2, 122);
            7'd16: p = sp(-243, -218);  7'd17: p = sp(-217, -192);
            7'd18: p = sp(-189, -164);  7'd19: p = sp(-163, -138);
            7'd20: p = sp(-136, -111);  7'd21: p = sp(-109, -84);
            7'd22: p = sp(-83, -58);    7'd23: p = sp(-55, -30);
            7'd24: p = sp(-29, -4);     7'd25: p = sp(4, 29);
            7'd26: p = sp(30, 55);      7'd27: p = sp(58, 83);
            7'd28: p = sp(84, 109);     7'd29: p = sp(111, 136);
            7'd30: p = sp(138, 163);    7'd31: p = sp(164, 189);
            7'd32: p = sp(192, 217);    7'd33: p = sp(218, 243);
            7'd34: p = sp(-243, -192);  7'd35: p = sp(-189, -138);
            7'd36: p = sp(-109, -58);   7'd37: p = sp(-55, -4);
            7'd38: p = sp(4, 55);       7'd39: p = sp(58, 109);
            7'd40: p = sp(138, 189);    7'd41: p = sp(192, 243);
            7'd42: p = sp(-243, -138);  7'd43: p = sp(-109, -4);
            7'd44: p = sp(4, 109);      7'd45: p = sp(138, 243);
            7'd46: p = sp(-244, -3);    7'd47: p = sp(3, 244);
            7'd48: p = dp(-244, -3, 3, 244);
            7'd49: p = sp(-499, -474);  7'd50: p = sp(-473, -448);
            7'd51: p = sp(-445, -420);  7'd52: p = sp(-419, -394);
            7'd53: p = sp(-392, -367);  7'd54: p = sp(-365, -340);
            7'd55: p = sp(-339, -314);  7'd56: p = sp(-311, -286);
            7'd57: p = sp(-285, -260);  7'd58: p = sp(-257, -232);
            7'd59: p = sp(-231, -206);  7'd60: p = sp(-203, -178);
            7'd61: p = sp(-177, -152);  7'd62: p = sp(-150, -125);
            7'd63: p = sp(-123, -98);   7'd64: p = sp(-97, -72);
            7'd65: p = sp(-69, -44);    7'd66: p = sp(-43, -18);
            7'd67: p = dp(-16, -4, 4, 16);
            7'd68: p = sp(18, 43);      7'd69: p = sp(44, 69);
            7'd70: p = sp(72, 97);      7'd71: p = sp(98, 123);
            7'd72: p = sp(125, 150);    7'd73: p = sp(152, 177);
            7'd74: p = sp(178, 203);    7'd75: p = sp(206, 231);
            7'd76: p = sp(232, 257);    7'd77: p = sp(260, 285);
            7'd78: p = sp(286, 311);    7'd79: p = sp(314, 339);
            7'd80: p = sp(340, 365);    7'd81: p = sp(367, 392);
            7'd82: p = sp(394, 419);    7'd83: p = sp(420, 445);
            7'd84: p = sp(448, 473);    7'd85: p = sp(474, 499);
            7'd86: p = sp(-499, -448);  7'd87: p = sp(-445, -394);
            7'd88: p = sp(-365, -314);  7'd89: p = sp(-311, -260);
            7'd90: p = sp(-257, -206);  7'd91: p = sp(-203, -152);
            7'd92: p = sp(-123, -72);   7'd93: p = sp(-69, -18);
            7'd94: p = sp(18, 69);      7'd95: p = sp(72, 123);
            7'd96: p = sp(152, 203);    7'd97: p = sp(206, 257);
            7'd98: p = sp(260, 311);    7'd99: p = sp(314, 365);
            7'd100: p = sp(394, 445);   7'd101: p = sp(448, 499);
            7'd102: p = sp(-499, -394); 7'd103: p = sp(-365, -260);
            7'd104: p = sp(-257, -152); 7'd105: p = sp(-123, -18);
            7'd106: p = sp(18, 123);    7'd107: p = sp(152, 257);
            7'd108: p = sp(260, 365);   7'd109: p = sp(394, 499);
            7'd110: p = sp(-500, -259); 7'd111: p = sp(-258, -17);
            7'd112: p = sp(17, 258);    7'd113: p = sp(259, 500);
            7'd114: p = sp(-500, -17);  7'd115: p = sp(17, 500);
            7'd116: p = dp(-500, -3, 3, 500);
            default: p = sp(0, 0);
        endcase
        return p;
    endfunction

endpackage

### rtl/ruof_datapath.sv
module ruof_datapath (
    input  logic           i_clk,
    input  logic [1:0]     i_channel_width,
    input  logic [2:0]     i_ref_type,
    input  logic [6:0]     i_ref_index,
    input  logic           i_ref_primary,
    input  logic [2:0]     i_searched_type,
    input  ruof_pkg::t_cmd i_cmd,
    output ruof_pkg::t_sts o_sts,
    output logic [6:0]     o_found_index,
    output logic           o_found_primary,
    output logic [1:0]     o_status
);
    import ruof_pkg::*;

    logic [1:0]  r_w;
    logic [2:0]  r_st;
    logic        r_rp;
    logic        r_all;
    t_pair       r_ref;
    logic        r_bad;
    logic [5:0]  r_n;
    logic [6:0]  r_total;
    logic [6:0]  r_g;
    logic [6:0]  r_cbase;

    logic [1:0]  pw;
    logic [5:0]  rn;
    logic [6:0]  rlocal;
    logic        rsec;
    logic [6:0]  rbase;
    logic        rbad;
    t_pair       rp;
    t_pair       rsh;
    logic [5:0]  sn;
    logic        c160;
    logic        csec;
    logic [6:0]  clocal;
    t_pair       cp;
    t_pair       csh;
    logic        cprim;
    logic        ov;
    logic        hit;

    function automatic t_pair shift_pair(input t_pair p, input logic on, input logic up);
        t_pair q;
        t_tone d;
        d = on ? (up ? t_tone'(512) : t_tone'(-512)) : t_tone'(0);
        q.lo0 = p.lo0 + d;
        q.hi0 = p.hi0 + d;
        q.lo1 = p.lo1 + d;
        q.hi1 = p.hi1 + d;
        return q;
    endfunction

    function automatic logic olap(input t_tone al, input t_tone ah, input t_tone bl,
                                  input t_tone bh);
        return (ah >= bl) && (bh >= al);
    endfunction

    assign pw     = (i_channel_width == W_160) ? 2'd2 : i_channel_width;
    assign rn     = ru_count(pw, i_ref_type);
    assign rsec   = (i_channel_width == W_160) && (i_ref_index > {1'b0, rn});
    assign rlocal = rsec ? (i_ref_index - {1'b0, rn}) : i_ref_index;
    assign rbad   = (rn == 6'd0) || (rlocal == 7'd0) || (rlocal > {1'b0, rn});
    assign rbase  = ru_base(pw, i_ref_type) + rlocal - 7'd1;
    assign rp     = plan(rbase);
    assign rsh    = shift_pair(rp, i_channel_width == W_160, rsec);
    assign sn     = ru_count(pw, i_searched_type);

    assign c160   = (r_w == W_160);
    assign csec   = c160 && (r_g > {1'b0, r_n});
    assign clocal = csec ? (r_g - {1'b0, r_n}) : r_g;
    assign cp     = plan(r_cbase + clocal - 7'd1);
    assign csh    = shift_pair(cp, c160, csec);
    assign cprim  = c160 ? !csec : r_rp;
    assign ov     = olap(r_ref.lo0, r_ref.hi0, csh.lo0, csh.hi0)
                 || olap(r_ref.lo0, r_ref.hi0, csh.lo1, csh.hi1)
                 || olap(r_ref.lo1, r_ref.hi1, csh.lo0, csh.hi0)
                 || olap(r_ref.lo1, r_ref.hi1, csh.lo1, csh.hi1);
    assign hit    = (r_g <= r_total) && (r_g != 7'd0)
                 && (r_all || ((cprim == r_rp) && ov));

    assign o_sts.ref_bad = r_bad;
    assign o_sts.direct  = c160 && (r_st == T_2X996);
    assign o_sts.last    = (r_g >= r_total);
    assign o_sts.hit     = hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w     <= i_channel_width;
            r_st    <= i_searched_type;
            r_rp    <= i_ref_primary;
            r_all   <= (i_channel_width == W_160) && (i_ref_type == T_2X996);
            r_bad   <= !((i_channel_width == W_160) && (i_ref_type == T_2X996)) && rbad;
            r_ref   <= rsh;
            r_n     <= sn;
            r_total <= (i_channel_width == W_160) ? {sn, 1'b0} : {1'b0, sn};
            r_cbase <= ru_base(pw, i_searched_type);
            r_g     <= 7'd1;
        end else if (i_cmd.step) begin
            r_g     <= r_g + 7'd1;
        end
    end

    always_comb begin
        o_found_index   = 7'd0;
        o_found_primary = 1'b0;
        o_status        = ST_NONE;
        if (r_bad) begin
            o_status = ST_INVALID;
        end else if (c160 && (r_st == T_2X996)) begin
            o_found_index   = 7'd1;
            o_found_primary = 1'b1;
            o_status        = ST_FOUND;
        end else if (hit) begin
            o_found_index   = r_g;
            o_found_primary = cprim;
            o_status        = ST_FOUND;
        end
    end

endmodule

### rtl/ruof_ctrl.sv
module ruof_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  ruof_pkg::t_sts i_sts,
    output ruof_pkg::t_cmd o_cmd,
    output logic           o_capture
);
    import ruof_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       done;

    assign done      = i_sts.ref_bad || i_sts.direct || i_sts.hit || i_sts.last;
    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = (r_state == S_OUT);
    assign o_cmd.load = (r_state == S_IDLE) && i_valid;
    assign o_cmd.step = (r_state == S_RUN) && !done;
    assign o_capture = (r_state == S_RUN) && done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_RUN;
            S_RUN:  if (done) n_state = S_OUT;
            S_OUT:  if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/resource_unit_overlap_finder_core.sv
// OFDMA resource unit overlap finder.
// Input channel: i_valid / o_stall with fields i_channel_width, i_ref_type,
// i_ref_index, i_ref_primary, i_searched_type. A transfer happens on a
// rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_found_index, o_found_primary and
// o_status (0 found, 1 invalid reference, 2 no overlap). One result per
// input transfer.
// The datapath walks the candidate RUs of the searched size one per cycle,
// comparing both tone ranges of each against the reference, and stops at
// the first overlap or after the last candidate (up to 74 at 160 MHz). An
// invalid reference, a searched 2x996 at 160 MHz or an empty search stops
// at the first check. The result is registered as the walk stops and
// o_valid rises with it. One item is in flight at a time, so no new input
// is taken until the result is transferred. While o_valid is high and
// i_stall holds it, the result stays put and o_stall stays high. Synchronous
// reset returns the block to idle and drops any result not yet transferred.
module resource_unit_overlap_finder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_channel_width,
    input  logic [2:0] i_ref_type,
    input  logic [6:0] i_ref_index,
    input  logic       i_ref_primary,
    input  logic [2:0] i_searched_type,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_found_index,
    output logic       o_found_primary,
    output logic [1:0] o_status
);
    import ruof_pkg::*;

    t_cmd       cmd;
    t_sts       sts;
    logic       capture;
    logic [6:0] dp_index;
    logic       dp_primary;
    logic [1:0] dp_status;
    logic [6:0] r_index;
    logic       r_primary;
    logic [1:0] r_status;

    ruof_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_capture (capture)
    );

    ruof_datapath u_dp (
        .i_clk           (i_clk),
        .i_channel_width (i_channel_width),
        .i_ref_type      (i_ref_type),
        .i_ref_index     (i_ref_index),
        .i_ref_primary   (i_ref_primary),
        .i_searched_type (i_searched_type),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_found_index   (dp_index),
        .o_found_primary (dp_primary),
        .o_status        (dp_status)
    );

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_index   <= dp_index;
            r_primary <= dp_primary;
            r_status  <= dp_status;
        end
    end

    assign o_found_index   = r_index;
    assign o_found_primary = r_primary;
    assign o_status        = r_status;

endmodule

### bench/resource_unit_overlap_finder_core_tb.sv
module resource_unit_overlap_finder_core_tb;
    import ruof_pkg::*;

    typedef struct packed {
        logic [1:0] width;
        logic [2:0] rtype;
        logic [6:0] rindex;
        logic       rprimary;
        logic [2:0] stype;
    } t_query;

    typedef struct packed {
        logic [6:0] index;
        logic       primary;
        logic [1:0] status;
    } t_answer;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_channel_width = '0;
    logic [2:0] i_ref_type = '0;
    logic [6:0] i_ref_index = '0;
    logic       i_ref_primary = 1'b0;
    logic [2:0] i_searched_type = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [6:0] o_found_index;
    logic       o_found_primary;
    logic [1:0] o_status;

    resource_unit_overlap_finder_core uut (.*);

    always #4 i_clk = ~i_clk;

    t_query  pending_q[$];
    t_answer answers_q[$];
    int      send_idle_pct = 20;
    int      recv_idle_pct = 59;
    int      hold_off = 0;
    int      errors = 0;
    int      checked = 0;
    int      n_found = 0;
    int      n_invalid = 0;
    int      n_none = 0;

    // tone table entry count and offset, for the 80 MHz plan at 160
    function automatic int plan_count(input int w, input int t);
        int pw;
        pw = (w == 3) ? 2 : w;
        if (t > 7 || t < 0) return 0;
        case (pw)
            0: case (t) 0: return 9; 1: return 4; 2: return 2; 3: return 1;
                        default: return 0; endcase
            1: case (t) 0: return 18; 1: return 8; 2: return 4; 3: return 2;
                        4: return 1; default: return 0; endcase
            default: case (t) 0: return 37; 1: return 16; 2: return 8; 3: return 4;
                        4: return 2; 5: return 1; default: return 0; endcase
        endcase
        return 0;
    endfunction

    function automatic int plan_offset(input int w, input int t);
        int pw;
        pw = (w == 3) ? 2 : w;
        case (pw)
            0: case (t) 1: return 9; 2: return 13; 3: return 15;
                        default: return 0; endcase
            1: case (t) 0: return 16; 1: return 34; 2: return 42; 3: return 46;
                        4: return 48; default: return 0; endcase
            default: case (t) 0: return 49; 1: return 86; 2: return 102;
                        3: return 110; 4: return 114; 5: return 116;
                        default: return 0; endcase
        endcase
        return 0;
    endfunction

    function automatic bit tone_span(input int w, input int t, input int idx,
                                     output int r[4]);
        int n, loc, shift;
        t_pair p;
        n = plan_count(w, t);
        loc = idx;
        shift = 0;
        if (w == 3 && t == 6) begin
            r = '{-1012, -3, 3, 1012};
            return 1;
        end
        if (w == 3) begin
            shift = -512;
            if (idx > n) begin
                loc = idx - n;
                shift = 512;
            end
        end
        if (n == 0 || loc == 0 || loc > n) return 0;
        p = plan(7'(plan_offset(w, t) + loc - 1));
        r[0] = int'(p.lo0) + shift; r[1] = int'(p.hi0) + shift;
        r[2] = int'(p.lo1) + shift; r[3] = int'(p.hi1) + shift;
        return 1;
    endfunction

    function automatic t_answer find_overlap(input t_query q);
        t_answer a;
        int w, rr[4], cr[4], per80, total, cp;
        bit whole, hit;
        w = q.width;
        whole = (w == 3 && q.rtype == T_2X996);
        a = '{index: 0, primary: 0, status: ST_INVALID};
        if (!whole && !tone_span(w, q.rtype, q.rindex, rr)) return a;
        if (w == 3 && q.stype == T_2X996) return '{index: 1, primary: 1, status: ST_FOUND};
        per80 = plan_count(w, q.stype);
        total = (w == 3) ? 2 * per80 : per80;
        a.status = ST_NONE;
        for (int g = 1; g <= total; g++) begin
            cp = (w == 3) ? (g <= per80) : q.rprimary;
            hit = whole;
            if (!whole && cp == q.rprimary && tone_span(w, q.stype, g, cr))
                for (int i = 0; i < 4; i += 2)
                    for (int j = 0; j < 4; j += 2)
                        if (rr[i+1] >= cr[j] && cr[j+1] >= rr[i]) hit = 1;
            if (hit) return '{index: 7'(g), primary: 1'(cp), status: ST_FOUND};
        end
        return a;
    endfunction

    function automatic t_query rand_query();
        t_query q;
        int n;
        q.width = 2'($urandom_range(0, 3));
        q.rtype = 3'($urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(0, 6));
        q.stype = 3'($urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(0, 6));
        q.rprimary = 1'($urandom);
        n = plan_count(q.width, q.rtype) * ((q.width == 3) ? 2 : 1);
        if (n > 0 && $urandom_range(0, 9) != 0) begin
            q.rindex = 7'($urandom_range(1, n));
            if (q.width == 3 && $urandom_range(0, 4) != 0)
                q.rprimary = (q.rindex <= n / 2);
        end else begin
            q.rindex = 7'($urandom);
        end
        return q;
    endfunction

    task automatic enqueue(input t_query q);
        pending_q.insert(pending_q.size(), q);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) answers_q.insert(answers_q.size(),
                                          find_overlap({i_channel_width, i_ref_type,
                                                        i_ref_index, i_ref_primary,
                                                        i_searched_type}));
            if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_query q;
                q = pending_q.pop_front();
                i_valid <= 1'b1;
                {i_channel_width, i_ref_type, i_ref_index, i_ref_primary,
                 i_searched_type} <= q;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_answer e;
            if (answers_q.size() == 0) begin
                $display("%0t: unexpected result idx=%0d pri=%0d st=%0d", $time,
                         o_found_index, o_found_primary, o_status);
                errors++;
            end else begin
                e = answers_q.pop_front();
                checked++;
                case (e.status)
                    ST_FOUND: n_found++;
                    ST_INVALID: n_invalid++;
                    default: n_none++;
                endcase
                if (o_found_index !== e.index)
                    $display("%0t: found_index expected %0d got %0d", $time, e.index,
                             o_found_index);
                if (o_found_primary !== e.primary)
                    $display("%0t: found_primary expected %0d got %0d", $time,
                             e.primary, o_found_primary);
                if (o_status !== e.status)
                    $display("%0t: status expected %0d got %0d", $time, e.status, o_status);
                if (o_found_index !== e.index || o_found_primary !== e.primary
                    || o_status !== e.status) errors++;
            end
        end
        if (hold_off > 0) begin
            i_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial begin
        int w;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed
        enqueue('{0, 0, 1, 1, 0});
        enqueue('{0, 0, 9, 0, 3});
        enqueue('{0, 0, 5, 1, 1});
        enqueue('{0, 0, 10, 1, 0});
        enqueue('{0, 0, 0, 1, 0});
        enqueue('{0, 7, 1, 1, 0});
        enqueue('{0, 0, 1, 1, 7});
        enqueue('{0, 6, 1, 1, 0});
        enqueue('{0, 3, 1, 1, 4});
        enqueue('{1, 4, 1, 0, 0});
        enqueue('{1, 0, 18, 1, 2});
        enqueue('{2, 5, 1, 1, 0});
        enqueue('{2, 0, 37, 0, 5});
        enqueue('{2, 0, 19, 1, 1});
        enqueue('{3, 0, 74, 0, 0});
        enqueue('{3, 0, 1, 1, 0});
        enqueue('{3, 0, 38, 1, 0});
        enqueue('{3, 0, 75, 0, 0});
        enqueue('{3, 6, 127, 0, 5});
        enqueue('{3, 6, 0, 1, 7});
        enqueue('{3, 2, 9, 0, 6});
        enqueue('{3, 5, 2, 0, 0});
        enqueue('{3, 5, 1, 1, 1});
        enqueue('{3, 4, 127, 1, 6});
        for (int k = 0; k < 575; k++) enqueue(rand_query());
        wait (pending_q.size() == 0);
        @(posedge i_clk);
        hold_off <= 400;
        for (int k = 0; k < 575; k++) enqueue(rand_query());
        send_idle_pct = 59;
        recv_idle_pct = 20;
        wait (pending_q.size() == 0);
        for (int k = 0; k < 600; k++) enqueue(rand_query());
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait (pending_q.size() == 0);
        @(posedge i_clk);
        while (i_valid) @(posedge i_clk);
        wait (answers_q.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("Checked %0d transfers: %0d found, %0d invalid reference, %0d no overlap.",
                 checked, n_found, n_invalid, n_none);
        $display("All widths, RU sizes, index extremes and 160 MHz halves exercised.");
        if (errors == 0 && answers_q.size() == 0)
            $display("resource_unit_overlap_finder_core_tb OK");
        else
            $display("resource_unit_overlap_finder_core_tb NOT OK");
        $finish;
    end

    initial begin
        #10000000;
        $display("resource_unit_overlap_finder_core_tb NOT OK");
        $finish;
    end

endmodule
